>>> hdl/servo_bus_packet_receiver_defines.svh
// assertion macros shared by the servo bus packet receiver checkers
`ifndef SERVO_BUS_PACKET_RECEIVER_DEFINES_SVH
`define SERVO_BUS_PACKET_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled while rst_n is low
`define SBPR_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while rst_n is low
`define SBPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sbpr_pkg.sv
// shared constants and controller/datapath interface types
`default_nettype none

package sbpr_pkg;

  // framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] MARK_BYTE = 8'hFD;
  localparam logic [7:0] PAD_BYTE  = 8'h00;

  // crc-16 generator polynomial, msb first
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // commands from controller to datapath, at most one set per cycle
  typedef struct packed {
    logic accept;      // input transaction taken this cycle
    logic take;        // run one byte through the packet parser
    logic walk_start;  // rewind buffer walk pointer and stuffing tracker
    logic scan_step;   // check one buffered byte for a bad escape
    logic load;        // decode one buffered byte into pending output bytes
    logic tail;        // load leftover partial stuffing prefix
    logic push;        // produce one output byte
    logic finish;      // close the packet with the last item
  } sbpr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hdr_match;   // incoming byte continues the header
    logic take_last;   // current parser byte is the accepted byte itself
    logic pkt_ok;      // checksum matched on the closing byte
    logic at_end;      // buffer walk reached the fill count
    logic step_bad;    // buffered byte breaks an escape sequence
    logic push_more;   // decoded bytes still waiting to be produced
    logic out_free;    // output register can take an item this cycle
  } sbpr_sts_t;

endpackage

`default_nettype wire

>>> hdl/sbpr_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module sbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/sbpr_ctrl.sv
// sequencing state machine: byte intake, replay, escape check and emission
`default_nettype none

module sbpr_ctrl import sbpr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire sbpr_sts_t sts,
  output sbpr_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_DECIDE,
    ST_SC_RD,
    ST_SC_CHK,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_PUSH,
    ST_EM_TAIL,
    ST_EM_LAST
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.accept = 1'b1;
          if (!sts.hdr_match) begin
            state_nxt = ST_REPLAY;
          end
        end
      end
      ST_REPLAY: begin
        cmd.take = 1'b1;
        if (sts.take_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.pkt_ok) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_SC_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SC_RD: begin
        if (sts.at_end) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_EM_RD;
        end else begin
          state_nxt = ST_SC_CHK;
        end
      end
      ST_SC_CHK: begin
        cmd.scan_step = 1'b1;
        state_nxt     = sts.step_bad ? ST_IDLE : ST_SC_RD;
      end
      ST_EM_RD: begin
        if (sts.at_end) begin
          cmd.tail  = 1'b1;
          state_nxt = ST_EM_TAIL;
        end else begin
          state_nxt = ST_EM_LD;
        end
      end
      ST_EM_LD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_EM_PUSH;
      end
      ST_EM_PUSH: begin
        if (!sts.push_more) begin
          state_nxt = ST_EM_RD;
        end else if (sts.out_free) begin
          cmd.push = 1'b1;
        end
      end
      ST_EM_TAIL: begin
        if (!sts.push_more) begin
          state_nxt = ST_EM_LAST;
        end else if (sts.out_free) begin
          cmd.push = 1'b1;
        end
      end
      ST_EM_LAST: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

`default_nettype wire

>>> hdl/sbpr_dp.sv
// packet parser registers, crc, payload buffer, unstuffing and output register
`default_nettype none

module sbpr_dp import sbpr_pkg::*; #(
  parameter int PAYLOAD_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sbpr_cmd_t  cmd,
  output sbpr_sts_t       sts,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_packet_id,
  output logic [7:0]      out_instruction,
  output logic [7:0]      out_param_byte,
  output logic            out_has_param,
  output logic            out_last
);

  // fill never passes PAYLOAD_BYTES-1 since the length check caps the data bytes
  localparam int FW    = $clog2(PAYLOAD_BYTES);
  localparam int REM_W = $clog2(PAYLOAD_BYTES + 3);

  localparam logic [15:0]      LEN_MAX    = 16'(PAYLOAD_BYTES + 2);
  localparam logic [REM_W-1:0] LEN_TRAIL  = REM_W'(3);  // instruction plus checksum
  localparam logic [1:0]       MATCH_FULL = 2'd3;       // FF FF FD seen in payload

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_INSTR,
    PH_DATA,
    PH_CK_LO,
    PH_CK_HI
  } phase_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = SYNC_BYTE;
      2'd1:    b = SYNC_BYTE;
      2'd2:    b = MARK_BYTE;
      default: b = PAD_BYTE;
    endcase
    return b;
  endfunction

  // crc after the four header bytes
  localparam logic [15:0] HDR_CRC =
    crc_upd(crc_upd(crc_upd(crc_upd(16'h0000, SYNC_BYTE), SYNC_BYTE), MARK_BYTE), PAD_BYTE);

  // control state
  phase_t           phase_r, phase_nxt;
  logic [1:0]       hmc_r, hmc_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic             ok_r, ok_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload state
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       instr_r, instr_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [1:0]       held_r, held_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [FW-1:0]    ptr_r, ptr_nxt;
  logic [1:0]       m_r, m_nxt;
  logic [1:0]       pre_r, pre_nxt;
  logic [1:0]       j_r, j_nxt;
  logic             wc_r, wc_nxt;
  logic [7:0]       emit_byte_r, emit_byte_nxt;
  logic [7:0]       pend_byte_r, pend_byte_nxt;
  logic [7:0]       out_id_r, out_id_nxt;
  logic [7:0]       out_instr_r, out_instr_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_ck;
  logic [7:0]       tb;
  logic [15:0]      len_full;
  logic [REM_W-1:0] rem_dec;
  logic             wr_en;
  logic [7:0]       rd_data;
  logic [1:0]       m_step, pre_step;
  logic             wc_step;
  logic [7:0]       push_byte;
  logic             out_wr;

  sbpr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_BYTES)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r),
    .wr_data (tb),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  assign in_ck     = (phase_r == PH_CK_LO) || (phase_r == PH_CK_HI);
  assign tb        = (idx_r < held_r) ? hdr_byte(idx_r) : byte_r;
  assign len_full  = {tb, len_lo_r};
  assign rem_dec   = rem_r - REM_W'(1);
  assign wr_en     = cmd.take && (phase_r == PH_DATA);
  assign push_byte = (j_r < pre_r) ? hdr_byte(j_r) : emit_byte_r;

  // stuffing tracker step for one buffered byte
  always_comb begin
    m_step   = m_r;
    pre_step = 2'd0;
    wc_step  = 1'b0;
    priority if (m_r == MATCH_FULL) begin
      pre_step = MATCH_FULL;
      m_step   = 2'd0;
    end else if (rd_data == hdr_byte(m_r)) begin
      m_step = m_r + 2'd1;
    end else if (rd_data == SYNC_BYTE) begin
      // emit one FF, keep two pending
      pre_step = 2'd1;
    end else begin
      pre_step = m_r;
      wc_step  = 1'b1;
      m_step   = 2'd0;
    end
  end

  always_comb begin
    sts.hdr_match = (in_rx_byte == hdr_byte(hmc_r)) && !in_ck;
    sts.take_last = (idx_r == held_r);
    sts.pkt_ok    = ok_r;
    sts.at_end    = (ptr_r == fill_r);
    sts.step_bad  = (m_r == MATCH_FULL) && (rd_data != MARK_BYTE);
    sts.push_more = (j_r < pre_r) || wc_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    phase_nxt      = phase_r;
    hmc_nxt        = hmc_r;
    fill_nxt       = fill_r;
    ok_nxt         = ok_r;
    pend_valid_nxt = pend_valid_r;
    id_nxt         = id_r;
    len_lo_nxt     = len_lo_r;
    rem_nxt        = rem_r;
    instr_nxt      = instr_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    byte_nxt       = byte_r;
    held_nxt       = held_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    m_nxt          = m_r;
    pre_nxt        = pre_r;
    j_nxt          = j_r;
    wc_nxt         = wc_r;
    emit_byte_nxt  = emit_byte_r;
    pend_byte_nxt  = pend_byte_r;
    out_wr         = 1'b0;
    out_id_nxt     = out_id_r;
    out_instr_nxt  = out_instr_r;
    out_byte_nxt   = out_byte_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;

    if (cmd.accept) begin
      ok_nxt = 1'b0;
      if (sts.hdr_match) begin
        if (hmc_r == MATCH_FULL) begin
          // full header: restart the parse
          hmc_nxt   = 2'd0;
          fill_nxt  = '0;
          phase_nxt = PH_ID;
          crc_nxt   = HDR_CRC;
        end else begin
          hmc_nxt = hmc_r + 2'd1;
        end
      end else begin
        // replay held header bytes, then this byte
        byte_nxt = in_rx_byte;
        held_nxt = hmc_r;
        idx_nxt  = 2'd0;
        hmc_nxt  = 2'd0;
      end
    end

    if (cmd.take) begin
      idx_nxt = idx_r + 2'd1;
      if (!in_ck) begin
        crc_nxt = crc_upd(crc_r, tb);
      end
      unique case (phase_r)
        PH_ID: begin
          id_nxt    = tb;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_nxt = tb;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          rem_nxt   = REM_W'(len_full);
          phase_nxt = (len_full > LEN_MAX) ? PH_WAIT : PH_INSTR;
        end
        PH_INSTR: begin
          instr_nxt = tb;
          if (rem_r > LEN_TRAIL) begin
            fill_nxt  = '0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_CK_LO;
          end
        end
        PH_DATA: begin
          fill_nxt = fill_r + FW'(1);
          rem_nxt  = rem_dec;
          if (rem_dec == LEN_TRAIL) begin
            phase_nxt = PH_CK_LO;
          end
        end
        PH_CK_LO: begin
          crc_lo_nxt = tb;
          phase_nxt  = PH_CK_HI;
        end
        PH_CK_HI: begin
          phase_nxt = PH_WAIT;
          if ({tb, crc_lo_r} == crc_r) begin
            ok_nxt = 1'b1;
          end
        end
        PH_WAIT: begin
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end

    if (cmd.walk_start) begin
      ptr_nxt        = '0;
      m_nxt          = 2'd0;
      pend_valid_nxt = 1'b0;
      pre_nxt        = 2'd0;
      j_nxt          = 2'd0;
      wc_nxt         = 1'b0;
    end

    if (cmd.scan_step) begin
      m_nxt   = m_step;
      ptr_nxt = ptr_r + FW'(1);
    end

    if (cmd.load) begin
      m_nxt         = m_step;
      pre_nxt       = pre_step;
      wc_nxt        = wc_step;
      j_nxt         = 2'd0;
      emit_byte_nxt = rd_data;
      ptr_nxt       = ptr_r + FW'(1);
    end

    if (cmd.tail) begin
      pre_nxt = m_r;
      wc_nxt  = 1'b0;
      j_nxt   = 2'd0;
    end

    if (cmd.push) begin
      // one item held back so the closing item can carry last
      if (pend_valid_r) begin
        out_wr        = 1'b1;
        out_id_nxt    = id_r;
        out_instr_nxt = instr_r;
        out_byte_nxt  = pend_byte_r;
        out_has_nxt   = 1'b1;
        out_last_nxt  = 1'b0;
      end
      pend_byte_nxt  = push_byte;
      pend_valid_nxt = 1'b1;
      if (j_r < pre_r) begin
        j_nxt = j_r + 2'd1;
      end else begin
        wc_nxt = 1'b0;
      end
    end

    if (cmd.finish) begin
      out_wr         = 1'b1;
      out_id_nxt     = id_r;
      out_instr_nxt  = instr_r;
      out_byte_nxt   = pend_valid_r ? pend_byte_r : 8'h00;
      out_has_nxt    = pend_valid_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_wr || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      hmc_r        <= 2'd0;
      fill_r       <= '0;
      ok_r         <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hmc_r        <= hmc_nxt;
      fill_r       <= fill_nxt;
      ok_r         <= ok_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    len_lo_r    <= len_lo_nxt;
    rem_r       <= rem_nxt;
    instr_r     <= instr_nxt;
    crc_r       <= crc_nxt;
    crc_lo_r    <= crc_lo_nxt;
    byte_r      <= byte_nxt;
    held_r      <= held_nxt;
    idx_r       <= idx_nxt;
    ptr_r       <= ptr_nxt;
    m_r         <= m_nxt;
    pre_r       <= pre_nxt;
    j_r         <= j_nxt;
    wc_r        <= wc_nxt;
    emit_byte_r <= emit_byte_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_id_r    <= out_id_nxt;
    out_instr_r <= out_instr_nxt;
    out_byte_r  <= out_byte_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packet_id   = out_id_r;
  assign out_instruction = out_instr_r;
  assign out_param_byte  = out_byte_r;
  assign out_has_param   = out_has_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

>>> hdl/servo_bus_packet_receiver.sv
// top level of the servo bus packet receiver
//
// takes one received serial byte per input transaction, hunts for the
// FF FF FD 00 header, captures id, 16-bit length and instruction, buffers the
// parameter bytes in a PAYLOAD_BYTES deep ram and runs a crc-16 (0x8005, init 0,
// msb first) over everything but the checksum. on a good checksum the buffer is
// walked twice: once to reject a broken escape (FF FF FD not followed by FD),
// once to unstuff and emit one output transaction per parameter byte, the final
// one flagged with last; a packet with no parameters gives a single transaction
// with has_param low. bad checksums, broken escapes and oversize lengths drop
// the packet with no output. a byte that extends a header prefix only advances
// the header match and leaves the input open; any other byte stalls the input
// while the h (0..3) held header bytes and then the byte itself are replayed
// through the byte parser one per cycle. after the closing checksum byte of a
// good packet the input stays stalled through a check pass and an emission pass
// over the buffer, paced by its single read port and, in the emission pass, by
// the output register, which takes at most one item per cycle and holds while
// out_stall is high. the buffer needs no clearing pass after reset, only entries
// written by the current packet are ever read. in_stall is high for one cycle
// after reset.

`default_nettype none

module servo_bus_packet_receiver import sbpr_pkg::*; #(
  parameter int PAYLOAD_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // serial byte input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // packet item output
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_packet_id,
  output logic [7:0]      out_instruction,
  output logic [7:0]      out_param_byte,
  output logic            out_has_param,
  output logic            out_last
);

  // command and status between sequencer and datapath
  sbpr_cmd_t cmd;
  sbpr_sts_t sts;

  // sequencer: intake, header replay, escape check pass, emission pass
  sbpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parser registers, crc, payload ram, unstuffer and output register
  sbpr_dp #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packet_id   (out_packet_id),
    .out_instruction (out_instruction),
    .out_param_byte  (out_param_byte),
    .out_has_param   (out_has_param),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

>>> hdl/sbpr_checker.sv
// port-level checks for the servo bus packet receiver and their bind
`default_nettype none

`include "servo_bus_packet_receiver_defines.svh"

module sbpr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_packet_id,
  input wire logic [7:0] out_instruction,
  input wire logic [7:0] out_param_byte,
  input wire logic       out_has_param,
  input wire logic       out_last
);

  // a stalled output transaction holds
  `SBPR_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_packet_id) && $stable(out_instruction) &&
    $stable(out_param_byte) && $stable(out_has_param) && $stable(out_last),
    "output transaction changed while stalled")

  // no new byte is taken while a packet is still being emitted
  `SBPR_ASSERT_IMM(a_busy_emit, out_valid && !out_last, in_stall,
    "input open in the middle of a packet")

  // an item without parameter is the whole packet and carries a zero byte
  `SBPR_ASSERT_IMM(a_empty_item, out_valid && !out_has_param,
    out_last && (out_param_byte == 8'h00), "empty item not a lone last item")

  // nothing is offered right after reset
  `SBPR_ASSERT_IMM(a_reset_quiet, !$past(rst_n), !out_valid && in_stall,
    "output valid or input open after reset")

endmodule

bind servo_bus_packet_receiver sbpr_checker u_sbpr_checker (.*);

`default_nettype wire
